// File: design/glzw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glzw_pkg: shared types and constants of the GIF LZW decoder
// Holds the control state types, the action and status codes and the write
// port bundles of the string table and the output stack.
// ----------------------------------------------------------------------------
package glzw_pkg;

	localparam int CODE_W    = 12;
	localparam int SYM_W     = 8;
	localparam int STACK_AW  = 12;
	localparam int COUNT_W   = 13;
	localparam int BUF_W     = 32;
	localparam int HELD_W    = 6;
	localparam int CW_W      = 4;

	localparam logic [COUNT_W-1:0] WALK_LIMIT = 13'd4095;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;
	localparam logic [1:0] ACT_PULL  = 2'd3;

	localparam logic [3:0] ST_PIXEL  = 4'd0;
	localparam logic [3:0] ST_NEED   = 4'd1;
	localparam logic [3:0] ST_ACCEPT = 4'd2;
	localparam logic [3:0] ST_FULL   = 4'd3;
	localparam logic [3:0] ST_CLEAR  = 4'd4;
	localparam logic [3:0] ST_DONE   = 4'd5;
	localparam logic [3:0] ST_TRUNC  = 4'd6;
	localparam logic [3:0] ST_BAD    = 4'd7;
	localparam logic [3:0] ST_START  = 4'd8;

	typedef enum logic [1:0] {
		S_READY,
		S_EXEC,
		S_WALK,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RUN,
		PH_ENDED,
		PH_DONE,
		PH_TRUNC,
		PH_BAD
	} phase_t;

	typedef struct packed {
		logic                en;
		logic [STACK_AW-1:0] addr;
		logic [SYM_W-1:0]    data;
	} stack_wr_t;

	typedef struct packed {
		logic              en;
		logic [CODE_W-1:0] addr;
		logic [CODE_W-1:0] prefix;
		logic [SYM_W-1:0]  suffix;
	} table_wr_t;

endpackage
`default_nettype wire

// File: design/glzw_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glzw_table: LZW string table
// Prefix and suffix of each table entry in one synchronous memory with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module glzw_table import glzw_pkg::*; #(
	parameter int ENTRIES = 4096
) (
	input  wire logic              clk,
	input  wire table_wr_t         wr,
	input  wire logic [CODE_W-1:0] rd_addr,
	output logic      [CODE_W-1:0] rd_prefix,
	output logic      [SYM_W-1:0]  rd_suffix
);

	localparam int AW = $clog2(ENTRIES);

	logic [CODE_W+SYM_W-1:0] mem [ENTRIES];
	logic [CODE_W+SYM_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= {wr.prefix, wr.suffix};
		end
		rd_q <= mem[rd_addr[AW-1:0]];
	end

	assign rd_prefix = rd_q[CODE_W+SYM_W-1:SYM_W];
	assign rd_suffix = rd_q[SYM_W-1:0];

endmodule
`default_nettype wire

// File: design/glzw_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glzw_stack: output symbol stack
// Holds the current string in reverse order; one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module glzw_stack import glzw_pkg::*; (
	input  wire logic                clk,
	input  wire stack_wr_t           wr,
	input  wire logic [STACK_AW-1:0] rd_addr,
	output logic      [SYM_W-1:0]    rd_data
);

	logic [SYM_W-1:0] mem [2**STACK_AW];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: design/gif_lzw_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_decoder: pull-style GIF variable-width LZW decoder
// Start, data, end and pull transactions each give one result transaction.
// Start, data, end and a pull that pops the stack go through the ready and
// execute states, the popped symbol coming from the registered stack read.
// A pull that decodes a code then walks its chain, one table read per symbol.
// Reset clears the control state at once; the memories are not cleared.
// ----------------------------------------------------------------------------
module gif_lzw_decoder import glzw_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int MAX_CODE_BITS = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       action,
	input  wire logic [SYM_W-1:0] byte_value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [3:0]       status,
	output logic      [SYM_W-1:0] pixel_index
);

	localparam logic [COUNT_W-1:0] TE_LIM  = COUNT_W'(TABLE_ENTRIES);
	localparam logic [CW_W-1:0]    CW_MAX  = CW_W'(MAX_CODE_BITS);

	state_t               state_q, state_d;
	phase_t               phase_q, phase_d;
	logic [1:0]           act_q;
	logic [SYM_W-1:0]     byte_q;
	logic [BUF_W-1:0]     buf_q, buf_d;
	logic [HELD_W-1:0]    held_q, held_d;
	logic [CW_W-1:0]      cw_q, cw_d;
	logic [COUNT_W-1:0]   nfc_q, nfc_d;
	logic [CODE_W-1:0]    prior_q, prior_d;
	logic                 pv_q, pv_d;
	logic [SYM_W-1:0]     fs_q, fs_d;
	logic [CW_W-1:0]      root_q, root_d;
	logic [COUNT_W-1:0]   sc_q, sc_d;
	logic [CODE_W-1:0]    walk_q, walk_d;
	logic [COUNT_W-1:0]   top_q, top_d;
	logic [CODE_W-1:0]    code_q, code_d;
	logic                 pend_q, pend_d;
	logic                 bad_q, bad_d;
	logic                 out_valid_q;
	logic [3:0]           status_q;
	logic [SYM_W-1:0]     pixel_q;

	logic                 accept;
	logic                 slot_free;
	logic                 emit;
	logic [3:0]           emit_status;
	logic [SYM_W-1:0]     emit_pixel;
	logic [COUNT_W-1:0]   clr;
	logic [COUNT_W-1:0]   code_mask;
	logic [CODE_W-1:0]    code;
	logic [COUNT_W-1:0]   code13;
	logic [CODE_W-1:0]    cur_walk;
	logic [COUNT_W-1:0]   cur_top;
	logic [COUNT_W-1:0]   nfc_inc;
	logic [COUNT_W-1:0]   sc_dec;

	stack_wr_t            stk_wr;
	logic [SYM_W-1:0]     stk_rdata;
	table_wr_t            tbl_wr;
	logic [CODE_W-1:0]    tbl_prefix;
	logic [SYM_W-1:0]     tbl_suffix;

	assign in_stall    = (state_q != S_READY);
	assign accept      = in_valid && !in_stall;
	assign slot_free   = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pixel_index = pixel_q;

	assign clr       = COUNT_W'(1) << root_q;
	assign code_mask = (COUNT_W'(1) << cw_q) - COUNT_W'(1);
	assign code      = buf_q[CODE_W-1:0] & code_mask[CODE_W-1:0];
	assign code13    = {1'b0, code};
	assign cur_walk  = pend_q ? tbl_prefix : walk_q;
	assign cur_top   = pend_q ? top_q + COUNT_W'(1) : top_q;
	assign nfc_inc   = nfc_q + COUNT_W'(1);
	assign sc_dec    = sc_q - COUNT_W'(1);

	glzw_stack u_stack (
		.clk     (clk),
		.wr      (stk_wr),
		.rd_addr (sc_dec[STACK_AW-1:0]),
		.rd_data (stk_rdata)
	);

	glzw_table #(
		.ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk       (clk),
		.wr        (tbl_wr),
		.rd_addr   (cur_walk),
		.rd_prefix (tbl_prefix),
		.rd_suffix (tbl_suffix)
	);

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		buf_d       = buf_q;
		held_d      = held_q;
		cw_d        = cw_q;
		nfc_d       = nfc_q;
		prior_d     = prior_q;
		pv_d        = pv_q;
		fs_d        = fs_q;
		root_d      = root_q;
		sc_d        = sc_q;
		walk_d      = walk_q;
		top_d       = top_q;
		code_d      = code_q;
		pend_d      = pend_q;
		bad_d       = bad_q;
		emit        = 1'b0;
		emit_status = ST_BAD;
		emit_pixel  = '0;
		stk_wr      = '0;
		tbl_wr      = '0;

		case (state_q)
			S_READY: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end

			S_EXEC: begin
				if (slot_free) begin
					state_d = S_READY;
					emit    = 1'b1;
					if (act_q == ACT_START) begin
						if (byte_q < 8'd2 || byte_q > 8'd8) begin
							phase_d     = PH_BAD;
							emit_status = ST_BAD;
						end else begin
							root_d      = byte_q[CW_W-1:0];
							cw_d        = byte_q[CW_W-1:0] + CW_W'(1);
							nfc_d       = (COUNT_W'(1) << byte_q[CW_W-1:0]) + COUNT_W'(2);
							pv_d        = 1'b0;
							buf_d       = '0;
							held_d      = '0;
							sc_d        = '0;
							prior_d     = '0;
							fs_d        = '0;
							phase_d     = PH_RUN;
							emit_status = ST_START;
						end
					end else if (phase_q == PH_IDLE || phase_q == PH_BAD) begin
						emit_status = ST_BAD;
					end else if (phase_q == PH_DONE) begin
						emit_status = ST_DONE;
					end else if (phase_q == PH_TRUNC) begin
						emit_status = ST_TRUNC;
					end else if (act_q == ACT_DATA) begin
						if (phase_q == PH_ENDED) begin
							emit_status = ST_ACCEPT;
						end else if (held_q > HELD_W'(24)) begin
							emit_status = ST_FULL;
						end else begin
							buf_d       = buf_q | (BUF_W'(byte_q) << held_q);
							held_d      = held_q + HELD_W'(8);
							emit_status = ST_ACCEPT;
						end
					end else if (act_q == ACT_END) begin
						phase_d     = PH_ENDED;
						emit_status = ST_ACCEPT;
					end else if (sc_q != '0) begin
						sc_d        = sc_dec;
						emit_status = ST_PIXEL;
						emit_pixel  = stk_rdata;
					end else if (held_q < HELD_W'(cw_q)) begin
						if (phase_q == PH_ENDED) begin
							phase_d     = PH_TRUNC;
							emit_status = ST_TRUNC;
						end else begin
							emit_status = ST_NEED;
						end
					end else begin
						buf_d  = buf_q >> cw_q;
						held_d = held_q - HELD_W'(cw_q);
						if (code13 == clr + COUNT_W'(1)) begin
							phase_d     = PH_DONE;
							emit_status = ST_DONE;
						end else if (code13 == clr) begin
							cw_d        = root_q + CW_W'(1);
							nfc_d       = clr + COUNT_W'(2);
							pv_d        = 1'b0;
							emit_status = ST_CLEAR;
						end else if (code13 > nfc_q || (code13 == nfc_q && !pv_q)) begin
							phase_d     = PH_BAD;
							emit_status = ST_BAD;
						end else begin
							emit    = 1'b0;
							state_d = S_WALK;
							code_d  = code;
							pend_d  = 1'b0;
							if (code13 == nfc_q) begin
								stk_wr.en   = 1'b1;
								stk_wr.addr = '0;
								stk_wr.data = fs_q;
								top_d       = COUNT_W'(1);
								walk_d      = prior_q;
							end else begin
								top_d  = '0;
								walk_d = code;
							end
						end
					end
				end
			end

			S_WALK: begin
				if (pend_q) begin
					stk_wr.en   = 1'b1;
					stk_wr.addr = top_q[STACK_AW-1:0];
					stk_wr.data = tbl_suffix;
				end
				walk_d = cur_walk;
				top_d  = cur_top;
				if ({1'b0, cur_walk} >= clr) begin
					if (cur_top >= WALK_LIMIT || {1'b0, cur_walk} >= TE_LIM) begin
						bad_d   = 1'b1;
						pend_d  = 1'b0;
						state_d = S_FIN;
					end else begin
						pend_d = 1'b1;
					end
				end else begin
					bad_d   = 1'b0;
					pend_d  = 1'b0;
					state_d = S_FIN;
				end
			end

			S_FIN: begin
				if (slot_free) begin
					state_d = S_READY;
					emit    = 1'b1;
					if (bad_q) begin
						phase_d     = PH_BAD;
						emit_status = ST_BAD;
					end else begin
						fs_d = walk_q[SYM_W-1:0];
						if (pv_q && nfc_q < TE_LIM) begin
							tbl_wr.en     = 1'b1;
							tbl_wr.addr   = nfc_q[CODE_W-1:0];
							tbl_wr.prefix = prior_q;
							tbl_wr.suffix = walk_q[SYM_W-1:0];
							nfc_d         = nfc_inc;
							if (nfc_inc == (COUNT_W'(1) << cw_q) && cw_q < CW_MAX) begin
								cw_d = cw_q + CW_W'(1);
							end
						end
						prior_d     = code_q;
						pv_d        = 1'b1;
						sc_d        = top_q;
						emit_status = ST_PIXEL;
						emit_pixel  = walk_q[SYM_W-1:0];
					end
				end
			end

			default: begin
				state_d = S_READY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_READY;
			phase_q     <= PH_IDLE;
			buf_q       <= '0;
			held_q      <= '0;
			cw_q        <= CW_W'(3);
			nfc_q       <= COUNT_W'(6);
			prior_q     <= '0;
			pv_q        <= 1'b0;
			fs_q        <= '0;
			root_q      <= CW_W'(2);
			sc_q        <= '0;
			pend_q      <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			buf_q   <= buf_d;
			held_q  <= held_d;
			cw_q    <= cw_d;
			nfc_q   <= nfc_d;
			prior_q <= prior_d;
			pv_q    <= pv_d;
			fs_q    <= fs_d;
			root_q  <= root_d;
			sc_q    <= sc_d;
			pend_q  <= pend_d;
			bad_q   <= bad_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			byte_q <= byte_value;
		end
		walk_q <= walk_d;
		top_q  <= top_d;
		code_q <= code_d;
		if (emit) begin
			status_q <= emit_status;
			pixel_q  <= emit_pixel;
		end
	end

endmodule
`default_nettype wire
